[hdl/stdf_pkg.sv]
// Package for the stream timestamp discontinuity fixer.
// Holds the time, epoch and duration types, the "none" code and register indexes.
// No dependencies.
`default_nettype none

package stdf_pkg;

    typedef logic [63:0] time_t;
    typedef logic [31:0] dur_t;
    typedef logic [15:0] epoch_t;
    typedef logic [1:0]  stream_t;

    localparam time_t  NONE_TIME        = 64'h8000_0000_0000_0000;
    localparam epoch_t EPOCH_MAX        = 16'hFFFF;
    localparam dur_t   JUMP_LIMIT_RESET = 32'd10000000;
    localparam int     NUM_STREAMS_DEF  = 4;

    localparam logic REG_BEGIN_TIME = 1'b0;
    localparam logic REG_JUMP_LIMIT = 1'b1;

endpackage

`default_nettype wire

[hdl/stream_timestamp_discontinuity_fixer.sv]
// Top level of the stream timestamp discontinuity fixer.
// Depends on stdf_pkg for types and constants.
//
// Usage:
// Items enter on the in_valid/in_ready channel (stream, dts_in, pts_in,
// frame_duration) and one result item per packet of a stream below NUM_STREAMS
// leaves on the out_valid/out_ready channel (dts_out, pts_out, latest_end,
// jump_seen). A packet of a higher stream index is taken and dropped.
// An accepted item is held in an input register; once the result register is
// free, the whole correction is worked out by one pass of logic on the
// per-stream and shared state and written to the result register, which
// drives out_valid until the receiver takes it.
// One item is taken every cycle while the receiver keeps up; the per-stream
// state update in that single pass sets the rate.
// When the receiver stalls, the result waits in the result register while one
// more item can still be taken into the input register; in_ready falls only
// when both are full. Reset empties both registers and puts the last, shared
// and end times and every offset to none, the epochs to zero, begin_time to
// none and jump_limit to its default. The APB port writes begin_time at address
// 0 and jump_limit at address 8; writes are meant only while the block is idle.
`default_nettype none

module stream_timestamp_discontinuity_fixer #(
    parameter int NUM_STREAMS = stdf_pkg::NUM_STREAMS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,

    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [3:0]      paddr,
    input  wire logic [63:0]     pwdata,
    output logic [63:0]          prdata,
    output logic                 pready,

    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire stdf_pkg::stream_t stream,
    input  wire stdf_pkg::time_t dts_in,
    input  wire stdf_pkg::time_t pts_in,
    input  wire stdf_pkg::dur_t  frame_duration,

    output logic                 out_valid,
    input  wire logic            out_ready,
    output stdf_pkg::time_t      dts_out,
    output stdf_pkg::time_t      pts_out,
    output stdf_pkg::time_t      latest_end,
    output logic                 jump_seen
);

    import stdf_pkg::*;

    function automatic logic s_lt(input time_t a, input time_t b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic epoch_t epoch_inc(input epoch_t e);
        return (e == EPOCH_MAX) ? EPOCH_MAX : e + 16'd1;
    endfunction

    time_t   begin_time_reg;
    dur_t    jump_limit_reg;

    logic    v1_reg;
    stream_t s1_stream_reg;
    time_t   s1_dts_reg;
    time_t   s1_pts_reg;
    dur_t    s1_dur_reg;

    time_t   last_reg   [NUM_STREAMS];
    time_t   offset_reg [NUM_STREAMS];
    epoch_t  epoch_reg  [NUM_STREAMS];
    time_t   shared_reg;
    epoch_t  shared_epoch_reg;
    time_t   end_max_reg;

    logic    out_valid_reg;
    time_t   dts_out_reg;
    time_t   pts_out_reg;
    time_t   latest_end_reg;
    logic    jump_reg;

    logic    advance;
    logic    in_range;

    time_t   cur_last;
    time_t   cur_offset;
    epoch_t  cur_epoch;

    time_t   dts_v;
    time_t   pts_v;
    time_t   decode_base;
    time_t   anchor;
    time_t   step;
    time_t   delta;
    time_t   dur64;
    time_t   offset_next;
    time_t   shared_next;
    epoch_t  epoch_next;
    epoch_t  shared_epoch_next;
    logic    bcast;
    logic    jump_next;
    time_t   dts_fin;
    time_t   pts_fin;
    time_t   end_t;
    time_t   end_max_next;

    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_JUMP_LIMIT) ? {32'd0, jump_limit_reg} : begin_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            begin_time_reg <= NONE_TIME;
            jump_limit_reg <= JUMP_LIMIT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[3] == REG_JUMP_LIMIT)
            begin
                jump_limit_reg <= pwdata[31:0];
            end
            else
            begin
                begin_time_reg <= pwdata;
            end
        end
    end

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !v1_reg || advance;
    assign in_range = (32'(s1_stream_reg) < NUM_STREAMS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_stream_reg <= stream;
            s1_dts_reg    <= dts_in;
            s1_pts_reg    <= pts_in;
            s1_dur_reg    <= frame_duration;
        end
    end

    always_comb
    begin
        cur_last   = NONE_TIME;
        cur_offset = NONE_TIME;
        cur_epoch  = '0;
        for (int i = 0; i < NUM_STREAMS; i++)
        begin
            if (32'(s1_stream_reg) == i)
            begin
                cur_last   = last_reg[i];
                cur_offset = offset_reg[i];
                cur_epoch  = epoch_reg[i];
            end
        end
    end

    always_comb
    begin
        dur64             = {32'd0, s1_dur_reg};
        dts_v             = s1_dts_reg;
        pts_v             = s1_pts_reg;
        offset_next       = cur_offset;
        shared_next       = shared_reg;
        epoch_next        = cur_epoch;
        shared_epoch_next = shared_epoch_reg;
        bcast             = 1'b0;
        jump_next         = 1'b0;
        anchor            = begin_time_reg - s1_dts_reg;
        step              = s1_dts_reg - cur_last;
        delta             = cur_offset + dur64 - step;

        if (pts_v != NONE_TIME && s_lt(pts_v, dts_v))
        begin
            pts_v = dts_v;
        end
        decode_base = dts_v;

        if (cur_last == NONE_TIME)
        begin
            if (dts_v == NONE_TIME)
            begin
                decode_base = '0;
                dts_v       = '0;
                pts_v       = '0;
                anchor      = begin_time_reg;
            end
            else if (pts_v == NONE_TIME)
            begin
                pts_v = dts_v;
            end
            if (begin_time_reg != NONE_TIME)
            begin
                if (s_lt(anchor, shared_reg))
                begin
                    offset_next = shared_reg;
                end
                else
                begin
                    if (s_lt(shared_reg, anchor))
                    begin
                        shared_next = anchor;
                        bcast       = s_lt(cur_offset, shared_reg);
                    end
                    offset_next = anchor;
                end
            end
        end
        else if (dts_v == NONE_TIME)
        begin
            dts_v = cur_last + dur64;
            pts_v = dts_v;
        end
        else
        begin
            if (pts_v == NONE_TIME)
            begin
                pts_v = dts_v;
            end
            if (!s_lt('0, step) || s_lt(dur64 + {32'd0, jump_limit_reg}, step))
            begin
                jump_next   = 1'b1;
                offset_next = delta;
                if (cur_epoch == shared_epoch_reg)
                begin
                    shared_next       = delta;
                    epoch_next        = epoch_inc(cur_epoch);
                    shared_epoch_next = epoch_inc(cur_epoch);
                end
                else if (cur_epoch > shared_epoch_reg)
                begin
                    shared_next = delta;
                end
                else
                begin
                    if (s_lt(delta, shared_reg))
                    begin
                        offset_next = shared_reg;
                    end
                    else if (s_lt(shared_reg, delta))
                    begin
                        bcast       = 1'b1;
                        shared_next = delta;
                    end
                    epoch_next = epoch_inc(cur_epoch);
                end
            end
            else if (cur_epoch < shared_epoch_reg)
            begin
                epoch_next = shared_epoch_reg;
            end
        end

        dts_fin = dts_v;
        pts_fin = pts_v;
        if (offset_next != NONE_TIME)
        begin
            dts_fin = dts_v + offset_next;
            pts_fin = pts_v + offset_next;
        end
        end_t        = (s_lt(dts_fin, pts_fin) ? pts_fin : dts_fin) + dur64;
        end_max_next = s_lt(end_max_reg, end_t) ? end_t : end_max_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STREAMS; i++)
            begin
                last_reg[i]   <= NONE_TIME;
                offset_reg[i] <= NONE_TIME;
                epoch_reg[i]  <= '0;
            end
            shared_reg       <= NONE_TIME;
            shared_epoch_reg <= '0;
            end_max_reg      <= NONE_TIME;
            out_valid_reg    <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= v1_reg && in_range;
            if (v1_reg && in_range)
            begin
                for (int i = 0; i < NUM_STREAMS; i++)
                begin
                    if (32'(s1_stream_reg) == i)
                    begin
                        last_reg[i]   <= decode_base;
                        offset_reg[i] <= offset_next;
                        epoch_reg[i]  <= epoch_next;
                    end
                    else if (bcast)
                    begin
                        offset_reg[i] <= shared_next;
                    end
                end
                shared_reg       <= shared_next;
                shared_epoch_reg <= shared_epoch_next;
                end_max_reg      <= end_max_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && v1_reg && in_range)
        begin
            dts_out_reg    <= dts_fin;
            pts_out_reg    <= pts_fin;
            latest_end_reg <= end_max_next;
            jump_reg       <= jump_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign dts_out    = dts_out_reg;
    assign pts_out    = pts_out_reg;
    assign latest_end = latest_end_reg;
    assign jump_seen  = jump_reg;

endmodule

`default_nettype wire

[hdl/stdf_checker.sv]
// Port-level checker for the stream timestamp discontinuity fixer, and its bind.
// Depends on stdf_pkg and on the ports of stream_timestamp_discontinuity_fixer.
`default_nettype none

module stdf_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            in_valid,
    input wire logic            in_ready,
    input wire logic            out_valid,
    input wire logic            out_ready,
    input wire stdf_pkg::time_t dts_out,
    input wire stdf_pkg::time_t pts_out,
    input wire stdf_pkg::time_t latest_end
);

    import stdf_pkg::*;

    logic  seen_reg;
    time_t prev_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            seen_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            prev_end_reg <= latest_end;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dts_out) && $stable(pts_out)
            && $stable(latest_end))
        else $error("Stalled result item changed or was withdrawn.");

    a_end_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && seen_reg |-> !($signed(latest_end) < $signed(prev_end_reg)))
        else $error("Latest end time went backwards.");

    a_rise_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("Result item appeared without an item taken two cycles before.");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("Input stalled while no result item was waiting.");

endmodule

bind stream_timestamp_discontinuity_fixer stdf_checker u_stdf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .dts_out    (dts_out),
    .pts_out    (pts_out),
    .latest_end (latest_end)
);

`default_nettype wire
